// ===== src/perm_pkg.sv =====
// shared types, opcodes and sizes for the permutation enumerator
package perm_pkg;

  localparam int MAX_ELEMENTS_DEF = 8;
  localparam int QUEUE_DEPTH      = 4;

  localparam int OP_W    = 2;
  localparam int INDEX_W = 3;
  localparam int VALUE_W = 32;
  localparam int CFG_W   = 4;
  localparam int SLOT_W  = 3;
  localparam int N_RESET = 8;

  localparam logic [OP_W-1:0] OP_LOAD    = 2'd0;
  localparam logic [OP_W-1:0] OP_RESTART = 2'd1;
  localparam logic [OP_W-1:0] OP_NEXT    = 2'd2;

  typedef enum logic [1:0] {
    CMD_LOAD,
    CMD_RESTART,
    CMD_NEXT
  } cmd_code_t;

  typedef struct packed {
    cmd_code_t                  code;
    logic [INDEX_W-1:0]         index;
    logic signed [VALUE_W-1:0]  value;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ===== src/permutation_enumerator.sv =====
// top level of the permutation enumerator: front, command queue and back
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_stall  in_opcode, in_index, in_value
//   out      output     out_valid / out_stall out_value, out_slot, out_last_of_run,
//                                            out_exhausted
//   cfg      input      cfg_we               cfg_wdata (n_used)
//
// a next item with n active elements emits the run through the output register,
// then finds the pivot and its swap partner, swaps them and runs n odd-even sort
// passes over the suffix; load and restart items are handled in the idle state.
// the front keeps taking items into a four-entry queue while the back works.
// rst_n is synchronous; it restores identity order and n_used, the store stays as is.
// a stalled output holds its item and the back waits on it.
module permutation_enumerator #(
  parameter int MAX_ELEMENTS = perm_pkg::MAX_ELEMENTS_DEF,
  parameter int QUEUE_DEPTH  = perm_pkg::QUEUE_DEPTH
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [perm_pkg::CFG_W-1:0]           cfg_wdata,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [perm_pkg::OP_W-1:0]            in_opcode,
  input  logic [perm_pkg::INDEX_W-1:0]         in_index,
  input  logic signed [perm_pkg::VALUE_W-1:0]  in_value,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [perm_pkg::VALUE_W-1:0]  out_value,
  output logic [perm_pkg::SLOT_W-1:0]          out_slot,
  output logic                                 out_last_of_run,
  output logic                                 out_exhausted
);

  perm_pkg::q_status_t q_status;
  perm_pkg::cmd_t      push_cmd;
  perm_pkg::cmd_t      head_cmd;
  logic                q_push;
  logic                q_pop;

  perm_front #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_front (
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_opcode (in_opcode),
    .in_index  (in_index),
    .in_value  (in_value),
    .q_status  (q_status),
    .q_push    (q_push),
    .q_cmd     (push_cmd)
  );

  perm_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .head_cmd (head_cmd),
    .status   (q_status)
  );

  perm_back #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .q_cmd           (head_cmd),
    .q_status        (q_status),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_value       (out_value),
    .out_slot        (out_slot),
    .out_last_of_run (out_last_of_run),
    .out_exhausted   (out_exhausted)
  );

`ifndef ASSERT_OFF
  a_exh_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_exhausted |-> out_value == '0 && out_slot == '0 && !out_last_of_run)
    else $error("exhausted item carries nonzero fields");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_status.full)
    else $error("front pushed into a full queue");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_status.empty)
    else $error("back popped an empty queue");

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");
`endif

endmodule

// ===== src/perm_front.sv =====
// front end: takes input items, drops the ones with no effect, queues commands
module perm_front #(
  parameter int MAX_ELEMENTS = perm_pkg::MAX_ELEMENTS_DEF
) (
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [perm_pkg::OP_W-1:0]            in_opcode,
  input  logic [perm_pkg::INDEX_W-1:0]         in_index,
  input  logic signed [perm_pkg::VALUE_W-1:0]  in_value,
  input  perm_pkg::q_status_t                  q_status,
  output logic                                 q_push,
  output perm_pkg::cmd_t                       q_cmd
);

  logic keep;

  always_comb begin
    keep       = 1'b0;
    q_cmd.code = perm_pkg::CMD_NEXT;
    unique case (in_opcode)
      perm_pkg::OP_LOAD: begin
        keep       = (32'(in_index) < 32'(MAX_ELEMENTS));
        q_cmd.code = perm_pkg::CMD_LOAD;
      end
      perm_pkg::OP_RESTART: begin
        keep       = 1'b1;
        q_cmd.code = perm_pkg::CMD_RESTART;
      end
      perm_pkg::OP_NEXT: begin
        keep       = 1'b1;
        q_cmd.code = perm_pkg::CMD_NEXT;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
    q_cmd.index = in_index;
    q_cmd.value = in_value;
  end

  assign in_stall = q_status.full;
  // an unused opcode or an out-of-range load is consumed and dropped here
  assign q_push   = in_valid && !in_stall && keep;

endmodule

// ===== src/perm_fifo.sv =====
// short command queue between front and back
module perm_fifo #(
  parameter int DEPTH = perm_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  perm_pkg::cmd_t      push_cmd,
  input  logic                pop,
  output perm_pkg::cmd_t      head_cmd,
  output perm_pkg::q_status_t status
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  perm_pkg::cmd_t   entry_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign status.full  = (count_r == CNT_W'(DEPTH));
  assign status.empty = (count_r == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head_cmd     = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ===== src/perm_back.sv =====
// back end: element store, position order, result emission and order advance
module perm_back #(
  parameter int MAX_ELEMENTS = perm_pkg::MAX_ELEMENTS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [perm_pkg::CFG_W-1:0]           cfg_wdata,
  input  perm_pkg::cmd_t                       q_cmd,
  input  perm_pkg::q_status_t                  q_status,
  output logic                                 q_pop,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [perm_pkg::VALUE_W-1:0]  out_value,
  output logic [perm_pkg::SLOT_W-1:0]          out_slot,
  output logic                                 out_last_of_run,
  output logic                                 out_exhausted
);

  localparam int IDX_W = $clog2(MAX_ELEMENTS);
  localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
  localparam int N_RST = (MAX_ELEMENTS > perm_pkg::N_RESET) ? perm_pkg::N_RESET : MAX_ELEMENTS;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EMIT,
    ST_FIND_I,
    ST_FIND_J,
    ST_SWAP,
    ST_SORT
  } state_t;

  state_t                             state_r, state_nxt;
  logic signed [perm_pkg::VALUE_W-1:0] store_r [MAX_ELEMENTS];
  logic [IDX_W-1:0]                   order_r [MAX_ELEMENTS];
  logic [IDX_W-1:0]                   order_nxt [MAX_ELEMENTS];
  logic [CNT_W-1:0]                   n_act_r, n_act_nxt;
  logic                               done_r, done_nxt;
  logic [IDX_W-1:0]                   k_r, k_nxt;
  logic [IDX_W-1:0]                   i_r, i_nxt;
  logic [IDX_W-1:0]                   j_r, j_nxt;
  logic [IDX_W-1:0]                   pivot_r, pivot_nxt;
  logic [CNT_W-1:0]                   pass_r, pass_nxt;

  logic                               out_valid_r, out_valid_nxt;
  logic signed [perm_pkg::VALUE_W-1:0] out_value_r, out_value_nxt;
  logic [perm_pkg::SLOT_W-1:0]        out_slot_r, out_slot_nxt;
  logic                               out_last_r, out_last_nxt;
  logic                               out_exh_r, out_exh_nxt;

  logic                               out_free;
  logic                               store_we;
  logic [IDX_W+perm_pkg::INDEX_W-1:0] load_wide;
  logic [IDX_W-1:0]                   load_addr;
  logic                               asc_found;
  logic [IDX_W-1:0]                   asc_idx;
  logic [IDX_W-1:0]                   gt_idx;
  logic [IDX_W-1:0]                   pivot_rd;
  logic                               run_last;
  logic [CNT_W-1:0]                   cfg_n;

  assign out_free  = !out_valid_r || !out_stall;
  assign load_wide = {{IDX_W{1'b0}}, q_cmd.index};
  assign load_addr = load_wide[IDX_W-1:0];
  assign pivot_rd  = order_r[i_r];
  assign run_last  = ((CNT_W'(k_r) + 1'b1) == n_act_r);

  // n_used of zero acts as one, large values act as the element count
  always_comb begin
    if (cfg_wdata == '0) begin
      cfg_n = CNT_W'(1);
    end else if (32'(cfg_wdata) > 32'(MAX_ELEMENTS)) begin
      cfg_n = CNT_W'(MAX_ELEMENTS);
    end else begin
      cfg_n = CNT_W'(cfg_wdata);
    end
  end

  // rightmost ascent among the active positions
  always_comb begin
    asc_found = 1'b0;
    asc_idx   = '0;
    for (int k = 0; k < MAX_ELEMENTS - 1; k++) begin
      if (CNT_W'(k + 1) < n_act_r && order_r[k] < order_r[k + 1]) begin
        asc_found = 1'b1;
        asc_idx   = IDX_W'(k);
      end
    end
  end

  // rightmost position past the pivot holding a larger entry
  always_comb begin
    gt_idx = '0;
    for (int k = 0; k < MAX_ELEMENTS; k++) begin
      if (IDX_W'(k) > i_r && CNT_W'(k) < n_act_r && order_r[k] > pivot_rd) begin
        gt_idx = IDX_W'(k);
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    n_act_nxt     = n_act_r;
    done_nxt      = done_r;
    k_nxt         = k_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    pivot_nxt     = pivot_r;
    pass_nxt      = pass_r;
    order_nxt     = order_r;
    q_pop         = 1'b0;
    store_we      = 1'b0;
    out_valid_nxt = out_free ? 1'b0 : out_valid_r;
    out_value_nxt = out_value_r;
    out_slot_nxt  = out_slot_r;
    out_last_nxt  = out_last_r;
    out_exh_nxt   = out_exh_r;

    unique case (state_r)
      ST_IDLE: begin
        if (!q_status.empty) begin
          unique case (q_cmd.code)
            perm_pkg::CMD_LOAD: begin
              q_pop    = 1'b1;
              store_we = 1'b1;
            end
            perm_pkg::CMD_RESTART: begin
              q_pop    = 1'b1;
              done_nxt = 1'b0;
              for (int k = 0; k < MAX_ELEMENTS; k++) begin
                order_nxt[k] = IDX_W'(k);
              end
            end
            perm_pkg::CMD_NEXT: begin
              if (done_r) begin
                if (out_free) begin
                  q_pop         = 1'b1;
                  out_valid_nxt = 1'b1;
                  out_value_nxt = '0;
                  out_slot_nxt  = '0;
                  out_last_nxt  = 1'b0;
                  out_exh_nxt   = 1'b1;
                end
              end else begin
                q_pop     = 1'b1;
                k_nxt     = '0;
                state_nxt = ST_EMIT;
              end
            end
            default: begin
              q_pop = 1'b1;
            end
          endcase
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = store_r[order_r[k_r]];
          out_slot_nxt  = perm_pkg::SLOT_W'(k_r);
          out_last_nxt  = run_last;
          out_exh_nxt   = 1'b0;
          if (run_last) begin
            state_nxt = ST_FIND_I;
          end else begin
            k_nxt = k_r + 1'b1;
          end
        end
      end
      ST_FIND_I: begin
        if (asc_found) begin
          i_nxt     = asc_idx;
          state_nxt = ST_FIND_J;
        end else begin
          done_nxt  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_FIND_J: begin
        pivot_nxt = pivot_rd;
        j_nxt     = gt_idx;
        state_nxt = ST_SWAP;
      end
      ST_SWAP: begin
        order_nxt[i_r] = order_r[j_r];
        order_nxt[j_r] = pivot_r;
        pass_nxt       = '0;
        state_nxt      = ST_SORT;
      end
      ST_SORT: begin
        // odd-even transposition passes put the suffix back in ascending order
        for (int k = 0; k < MAX_ELEMENTS - 1; k++) begin
          if (IDX_W'(k) > i_r && CNT_W'(k + 1) < n_act_r &&
              1'(k % 2) == pass_r[0] && order_r[k] > order_r[k + 1]) begin
            order_nxt[k]     = order_r[k + 1];
            order_nxt[k + 1] = order_r[k];
          end
        end
        if ((pass_r + 1'b1) >= n_act_r) begin
          state_nxt = ST_IDLE;
        end else begin
          pass_nxt = pass_r + 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // a register write restarts the enumeration
    if (cfg_we) begin
      n_act_nxt = cfg_n;
      done_nxt  = 1'b0;
      for (int k = 0; k < MAX_ELEMENTS; k++) begin
        order_nxt[k] = IDX_W'(k);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      n_act_r     <= CNT_W'(N_RST);
      done_r      <= 1'b0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < MAX_ELEMENTS; k++) begin
        order_r[k] <= IDX_W'(k);
      end
    end else begin
      state_r     <= state_nxt;
      n_act_r     <= n_act_nxt;
      done_r      <= done_nxt;
      out_valid_r <= out_valid_nxt;
      order_r     <= order_nxt;
    end
    k_r         <= k_nxt;
    i_r         <= i_nxt;
    j_r         <= j_nxt;
    pivot_r     <= pivot_nxt;
    pass_r      <= pass_nxt;
    out_value_r <= out_value_nxt;
    out_slot_r  <= out_slot_nxt;
    out_last_r  <= out_last_nxt;
    out_exh_r   <= out_exh_nxt;
  end

  always_ff @(posedge clk) begin
    if (store_we) begin
      store_r[load_addr] <= q_cmd.value;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_value       = out_value_r;
  assign out_slot        = out_slot_r;
  assign out_last_of_run = out_last_r;
  assign out_exhausted   = out_exh_r;

endmodule
